>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the unescaper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion that is checked during reset as well.
`define ASSERT_ANY(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Types, codes and helper functions shared by the unescaper modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
   localparam logic [2:0] ERR_CONTROL   = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
   localparam logic [2:0] ERR_NO_LOW    = 3'd4;
   localparam logic [2:0] ERR_BAD_LOW   = 3'd5;
   localparam logic [2:0] ERR_LONE_LOW  = 3'd6;
   localparam logic [2:0] ERR_TRUNCATED = 3'd7;

   // Characters of interest.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Surrogate ranges by their top six bits.
   localparam logic [5:0] SURR_HIGH = 6'b110110;
   localparam logic [5:0] SURR_LOW  = 6'b110111;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   localparam int MAX_RSP = 4;

   // Decoder phase, one-hot.
   typedef enum logic [13:0] {
      PH_IDLE  = 14'b00000000000001,
      PH_STR   = 14'b00000000000010,
      PH_ESC   = 14'b00000000000100,
      PH_HI0   = 14'b00000000001000,
      PH_HI1   = 14'b00000000010000,
      PH_HI2   = 14'b00000000100000,
      PH_HI3   = 14'b00000001000000,
      PH_BSL   = 14'b00000010000000,
      PH_U     = 14'b00000100000000,
      PH_LO0   = 14'b00001000000000,
      PH_LO1   = 14'b00010000000000,
      PH_LO2   = 14'b00100000000000,
      PH_LO3   = 14'b01000000000000,
      PH_DRAIN = 14'b10000000000000
   } phase_type;

   // One result item.
   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] out_byte;
      logic [2:0] error_code;
   } rsp_entry_type;

   // All results caused by one input item.
   typedef struct packed {
      logic [2:0]                  cnt;
      rsp_entry_type [MAX_RSP-1:0] ent;
   } rsp_group_type;

   // UTF-8 encoding of one code point.
   typedef struct packed {
      logic [2:0]       cnt;
      logic [3:0][7:0]  bytes;
   } utf8_type;

   // True for 0-9, a-f and A-F.
   function automatic logic hex_ok(input logic [7:0] b);
      hex_ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
   endfunction

   // Value of a hex digit; letters have a low nibble of one to six.
   function automatic logic [3:0] hex_val(input logic [7:0] b);
      if (b <= 8'h39) begin
         hex_val = b[3:0];
      end else begin
         hex_val = b[3:0] + 4'd9;
      end
   endfunction

   // UTF-8 encoder, first byte in the lowest lane.
   function automatic utf8_type utf8_enc(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.cnt      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         r.cnt      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         r.cnt      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.cnt      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

>>> design/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescaper decoder
// Next-state and result logic for one input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_decode (
   input  logic                  in_kind,
   input  logic [7:0]            in_byte,
   input  jsu_pkg::phase_type    phase_ff,
   input  logic [15:0]           acc_ff,
   input  logic [9:0]            hs_ff,
   output jsu_pkg::phase_type    phase_in,
   output logic [15:0]           acc_in,
   output logic [9:0]            hs_in,
   output jsu_pkg::rsp_group_type rsp
);
   import jsu_pkg::*;

   logic        h_ok;
   logic [15:0] cp_hex;
   logic [20:0] cp_pair;
   utf8_type    enc_hi;
   utf8_type    enc_pair;

   // Hex digit and the code points it completes.
   assign h_ok     = hex_ok(in_byte);
   assign cp_hex   = {acc_ff[11:0], hex_val(in_byte)};
   assign cp_pair  = SUPP_BASE + {1'b0, hs_ff, cp_hex[9:0]};
   assign enc_hi   = utf8_enc({5'd0, cp_hex});
   assign enc_pair = utf8_enc(cp_pair);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      hs_in    = hs_ff;
      rsp      = '0;

      if (in_kind) begin
         // End of data: truncated unless idle or draining.
         if (phase_ff != PH_IDLE && phase_ff != PH_DRAIN) begin
            rsp.cnt                   = 3'd1;
            rsp.ent[0].result_kind    = KIND_ERROR;
            rsp.ent[0].error_code     = ERR_TRUNCATED;
         end
         phase_in = PH_IDLE;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in = PH_STR;
               end else begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_NO_QUOTE;
               end
            end
            PH_STR: begin
               priority if (in_byte == CH_QUOTE) begin
                  phase_in = PH_IDLE;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_DONE;
               end else if (in_byte < CH_SPACE) begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_CONTROL;
               end else if (in_byte == CH_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  rsp.cnt = 3'd1;
                  rsp.ent[0].out_byte = in_byte;
               end
            end
            PH_ESC: begin
               // Single-character escapes and the start of a hex group.
               phase_in = PH_STR;
               rsp.cnt  = 3'd1;
               unique case (in_byte)
                  CH_QUOTE: rsp.ent[0].out_byte = CH_QUOTE;
                  CH_BSL:   rsp.ent[0].out_byte = CH_BSL;
                  CH_SLASH: rsp.ent[0].out_byte = CH_SLASH;
                  CH_B:     rsp.ent[0].out_byte = 8'h08;
                  CH_F:     rsp.ent[0].out_byte = 8'h0C;
                  CH_N:     rsp.ent[0].out_byte = 8'h0A;
                  CH_R:     rsp.ent[0].out_byte = 8'h0D;
                  CH_T:     rsp.ent[0].out_byte = 8'h09;
                  CH_U: begin
                     rsp.cnt  = 3'd0;
                     acc_in   = '0;
                     phase_in = PH_HI0;
                  end
                  default: begin
                     phase_in = PH_DRAIN;
                     rsp.ent[0].result_kind = KIND_ERROR;
                     rsp.ent[0].error_code  = ERR_BAD_ESC;
                  end
               endcase
            end
            PH_HI0, PH_HI1, PH_HI2, PH_LO0, PH_LO1, PH_LO2: begin
               if (!h_ok) begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_BAD_HEX;
               end else begin
                  acc_in   = cp_hex;
                  // One-hot: the next digit state is the next bit up.
                  phase_in = phase_type'({phase_ff[12:0], 1'b0});
               end
            end
            PH_HI3: begin
               if (!h_ok) begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_BAD_HEX;
               end else begin
                  acc_in = cp_hex;
                  priority if (cp_hex[15:10] == SURR_HIGH) begin
                     hs_in    = cp_hex[9:0];
                     phase_in = PH_BSL;
                  end else if (cp_hex[15:10] == SURR_LOW) begin
                     phase_in = PH_DRAIN;
                     rsp.cnt = 3'd1;
                     rsp.ent[0].result_kind = KIND_ERROR;
                     rsp.ent[0].error_code  = ERR_LONE_LOW;
                  end else begin
                     phase_in = PH_STR;
                     rsp.cnt  = enc_hi.cnt;
                     for (int i = 0; i < MAX_RSP; i++) begin
                        rsp.ent[i].out_byte = enc_hi.bytes[i];
                     end
                  end
               end
            end
            PH_LO3: begin
               if (!h_ok) begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_BAD_HEX;
               end else begin
                  acc_in = cp_hex;
                  if (cp_hex[15:10] != SURR_LOW) begin
                     phase_in = PH_DRAIN;
                     rsp.cnt = 3'd1;
                     rsp.ent[0].result_kind = KIND_ERROR;
                     rsp.ent[0].error_code  = ERR_BAD_LOW;
                  end else begin
                     phase_in = PH_STR;
                     rsp.cnt  = enc_pair.cnt;
                     for (int i = 0; i < MAX_RSP; i++) begin
                        rsp.ent[i].out_byte = enc_pair.bytes[i];
                     end
                  end
               end
            end
            PH_BSL: begin
               if (in_byte == CH_BSL) begin
                  phase_in = PH_U;
               end else begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_NO_LOW;
               end
            end
            PH_U: begin
               if (in_byte == CH_U) begin
                  acc_in   = '0;
                  phase_in = PH_LO0;
               end else begin
                  phase_in = PH_DRAIN;
                  rsp.cnt = 3'd1;
                  rsp.ent[0].result_kind = KIND_ERROR;
                  rsp.ent[0].error_code  = ERR_NO_LOW;
               end
            end
            PH_DRAIN: begin
               phase_in = PH_DRAIN;
            end
            default: begin
               phase_in = PH_DRAIN;
            end
         endcase
      end
   end

endmodule

>>> design/jsu_rsp_buf.sv
// ----------------------------------------------------------------------------
// JSON string unescaper result buffer
// Holds the results of one item and hands them out one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  jsu_pkg::rsp_group_type load_grp,
   output logic                   can_load,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output jsu_pkg::rsp_entry_type rsp_ent,
   output logic                   rsp_last
);
   import jsu_pkg::*;

   logic [2:0]                  cnt_ff, cnt_in;
   logic [1:0]                  idx_ff, idx_in;
   rsp_entry_type [MAX_RSP-1:0] ent_ff;
   logic                        take;

   // Current result and whether it is the final one of its item.
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_ent    = ent_ff[idx_ff];
   assign rsp_last   = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = !rsp_tvalid || (take && rsp_last);

   // Count and read index.
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = load_grp.cnt;
         idx_in = 2'd0;
      end else if (take && rsp_last) begin
         cnt_in = 3'd0;
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= load_grp.ent;
      end
   end

endmodule

>>> design/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes one JSON string literal per run into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one raw byte per item in req_tdata, with req_tuser
//   high for an end-of-data marker. Each item gives zero to four result items
//   on the rsp channel: decoded bytes, a string-complete mark or an error.
//   rsp_tlast marks the final result caused by one input item.
//   Latency: results appear on rsp the cycle after the input item is taken.
//   Throughput: one input item per cycle while each item gives at most one
//   result and rsp_tready stays high; an item with several results holds
//   req_tready low, as the buffer hands out one result per cycle while rsp is ready.
//   A new item is taken in the same cycle as the final buffered result goes.
//   Reset clears the decoder to idle (awaiting an opening quote) and empties
//   the result buffer. When the receiver stalls, the current result holds and
//   the input side stops once that result's item is fully buffered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] error_code, zero pad
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last result of the input item
);
   import jsu_pkg::*;

   phase_type     phase_ff, phase_in;
   logic [15:0]   acc_ff, acc_in;
   logic [9:0]    hs_ff, hs_in;
   rsp_group_type grp;
   rsp_entry_type ent;
   logic          accept;

   assign accept = req_tvalid && req_tready;

   // Decode of the incoming item against the current state.
   jsu_decode u_decode (
      .in_kind  (req_tuser),
      .in_byte  (req_tdata),
      .phase_ff (phase_ff),
      .acc_ff   (acc_ff),
      .hs_ff    (hs_ff),
      .phase_in (phase_in),
      .acc_in   (acc_in),
      .hs_in    (hs_in),
      .rsp      (grp)
   );

   // Decoder state advances on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         hs_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
      end
   end

   // Result register and serialiser.
   jsu_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_grp   (grp),
      .can_load   (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_ent    (ent),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, ent.error_code, ent.out_byte};
   assign rsp_tuser = ent.result_kind;

endmodule

>>> design/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescaper port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import jsu_pkg::*;

   logic [18:0] rsp_word;
   logic        rsp_stall;
   logic        fields_ok;

   // Everything the result channel shows, and whether it is held back.
   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // Errors carry no byte; bytes and completions carry no error code.
   assign fields_ok = (rsp_tuser == KIND_ERROR) ? (rsp_tdata[7:0] == 8'd0)
                                                : (rsp_tdata[10:8] == 3'd0);

   // The result buffer is empty after reset.
   `ASSERT_ANY(a_rst_empty, clock, reset |=> !rsp_tvalid)

   // A stalled result holds.
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word))

   // Only multi-byte encodings give several results, so non-final ones are bytes.
   `ASSERT_RST(a_multi_bytes, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tuser == KIND_BYTE)

   // Field contents match the result kind.
   `ASSERT_RST(a_fields, clock, reset, rsp_tvalid |-> fields_ok)

   // The input side waits while several results are still buffered.
   `ASSERT_RST(a_no_take_mid, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
